@@ rtl/u8u16_pkg.sv @@
// shared types, constants and helpers for the utf-8 to utf-16 decoder
package u8u16_pkg;

    localparam int unsigned POINT_W     = 21;
    localparam int unsigned UNIT_W      = 16;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [UNIT_W-1:0]  SURR_HI_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0]  SURR_LO_BASE = 16'hDC00;
    localparam logic [POINT_W-1:0] SUPP_OFFSET  = 21'h10000;

    // one decoded command handed from the front to the back
    typedef struct packed {
        logic [UNIT_W-1:0] unit0;
        logic [UNIT_W-1:0] unit1;
        logic              pair;
        logic              eos;
        logic              bad;
    } cmd_t;

    function automatic cmd_t point_cmd(input logic [POINT_W-1:0] cp);
        cmd_t               c;
        logic [POINT_W-1:0] v;
        c = '0;
        v = cp - SUPP_OFFSET;
        if (cp[POINT_W-1:UNIT_W] != '0) begin
            c.unit0 = SURR_HI_BASE + {6'd0, v[19:10]};
            c.unit1 = SURR_LO_BASE + {6'd0, v[9:0]};
            c.pair  = 1'b1;
        end else begin
            c.unit0 = cp[UNIT_W-1:0];
        end
        return c;
    endfunction

endpackage

@@ rtl/u8u16_front.sv @@
// byte intake, sequence tracking and command generation
module u8u16_front import u8u16_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic [1:0]         pending_reg, pending_next;
    logic [POINT_W-1:0] point_reg, point_next;
    logic               discard_reg, discard_next;
    logic [POINT_W-1:0] shifted;
    logic               accept;
    logic               emit;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign shifted = {point_reg[POINT_W-7:0], s_byte_in[5:0]};
    assign q_push  = accept && emit;

    always_comb begin
        pending_next = pending_reg;
        point_next   = point_reg;
        discard_next = discard_reg;
        emit         = 1'b0;
        q_cmd        = '0;
        if (discard_reg) begin
            if (s_byte_in == 8'd0) begin
                discard_next = 1'b0;
            end
        end else if (pending_reg != 2'd0) begin
            if (s_byte_in[7:6] != 2'b10) begin
                pending_next = 2'd0;
                point_next   = '0;
                discard_next = (s_byte_in != 8'd0);
                emit         = 1'b1;
                q_cmd.bad    = 1'b1;
            end else begin
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1) begin
                    point_next = '0;
                    emit       = 1'b1;
                    q_cmd      = point_cmd(shifted);
                end else begin
                    point_next = shifted;
                end
            end
        end else if (!s_byte_in[7]) begin
            emit = 1'b1;
            if (s_byte_in == 8'd0) begin
                q_cmd.eos = 1'b1;
            end else begin
                q_cmd = point_cmd({13'd0, s_byte_in});
            end
        end else if (s_byte_in[7:5] == 3'b110) begin
            pending_next = 2'd1;
            point_next   = {16'd0, s_byte_in[4:0]};
        end else if (s_byte_in[7:4] == 4'b1110) begin
            pending_next = 2'd2;
            point_next   = {17'd0, s_byte_in[3:0]};
        end else if (s_byte_in[7:3] == 5'b11110) begin
            pending_next = 2'd3;
            point_next   = {18'd0, s_byte_in[2:0]};
        end else begin
            pending_next = 2'd0;
            point_next   = '0;
            discard_next = 1'b1;
            emit         = 1'b1;
            q_cmd.bad    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            point_reg   <= '0;
            discard_reg <= 1'b0;
        end else if (accept) begin
            pending_reg <= pending_next;
            point_reg   <= point_next;
            discard_reg <= discard_next;
        end
    end

    a_discard_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        discard_reg |-> pending_reg == 2'd0)
        else $error("discarding with a sequence open");

endmodule

@@ rtl/u8u16_queue.sv @@
// short command queue between front and back
module u8u16_queue import u8u16_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

@@ rtl/u8u16_back.sv @@
// result sequencing and output register
module u8u16_back import u8u16_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  cmd_t              head_cmd,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [UNIT_W-1:0] m_code_unit,
    output logic              m_end_of_string,
    output logic              m_bad_sequence,
    output logic              m_last_of_run
);

    logic              valid_reg, valid_next;
    logic              phase_reg, phase_next;
    logic [UNIT_W-1:0] unit_reg, unit_next;
    logic              eos_reg, eos_next;
    logic              bad_reg, bad_next;
    logic              last_reg, last_next;
    logic              load;

    assign load = head_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        unit_next  = unit_reg;
        eos_next   = eos_reg;
        bad_next   = bad_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            eos_next   = head_cmd.eos;
            bad_next   = head_cmd.bad;
            if (head_cmd.pair && !phase_reg) begin
                // high surrogate beat, keep the entry
                unit_next  = head_cmd.unit0;
                last_next  = 1'b0;
                phase_next = 1'b1;
            end else begin
                unit_next  = phase_reg ? head_cmd.unit1 : head_cmd.unit0;
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        unit_reg <= unit_next;
        eos_reg  <= eos_next;
        bad_reg  <= bad_next;
        last_reg <= last_next;
    end

    assign m_valid         = valid_reg;
    assign m_code_unit     = unit_reg;
    assign m_end_of_string = eos_reg;
    assign m_bad_sequence  = bad_reg;
    assign m_last_of_run   = last_reg;

    a_phase_holds_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> head_valid && head_cmd.pair)
        else $error("second surrogate pending without a pair at the head");

    a_mark_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (eos_reg || bad_reg) |-> last_reg && unit_reg == '0)
        else $error("end or error beat not final or not zero");

endmodule

@@ rtl/utf8_to_utf16_decoder.sv @@
// utf-8 to utf-16 decoder top level
// Takes one UTF-8 byte per beat and returns UTF-16 code units, one per beat, with
// end_of_string on a clean terminating zero and bad_sequence on an invalid byte
// (bytes after an error are dropped up to the next zero). A new byte is accepted
// every cycle while the two-entry command queue has room; a code point above 0xFFFF
// gives two output beats (high then low surrogate) and comes only from four input
// bytes. The accepting edge of a byte writes its decoded command into the queue, and
// the output register loads it from the queue head once the entries ahead of it have
// gone out and the output is not stalled. Overlong forms and surrogate-range points
// are passed unchecked, and points above 0x10FFFF wrap in the surrogate arithmetic.
module utf8_to_utf16_decoder import u8u16_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_byte_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [UNIT_W-1:0] m_code_unit,
    output logic              m_end_of_string,
    output logic              m_bad_sequence,
    output logic              m_last_of_run
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_cmd;
    cmd_t q_head_cmd;

    u8u16_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    u8u16_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    u8u16_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (q_head_valid),
        .head_cmd        (q_head_cmd),
        .pop             (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_unit     (m_code_unit),
        .m_end_of_string (m_end_of_string),
        .m_bad_sequence  (m_bad_sequence),
        .m_last_of_run   (m_last_of_run)
    );

endmodule
